// ----- rtl/core/fbfl_pkg.sv -----
`default_nettype none

package fbfl_pkg;

	localparam int OFFSET_W    = 23;
	localparam int STATUS_W    = 3;
	localparam int NUM_ITEMS_W = 11;
	localparam int ITEM_SIZE_W = 13;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 13;

	localparam logic [CFG_IDX_W-1:0] CFG_NUM_ITEMS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ITEM_SIZE = 2'd1;

	localparam logic [NUM_ITEMS_W-1:0] NUM_ITEMS_RST = 11'd1024;
	localparam logic [ITEM_SIZE_W-1:0] ITEM_SIZE_RST = 13'd64;

	typedef enum logic [STATUS_W-1:0] {
		STAT_ALLOC = 3'd0,
		STAT_EMPTY = 3'd1,
		STAT_FREED = 3'd2,
		STAT_RANGE = 3'd3,
		STAT_ALIGN = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		KIND_ALLOC = 2'd0,
		KIND_RANGE = 2'd1,
		KIND_FREE  = 2'd2
	} kind_t;

	typedef struct packed {
		logic                func;
		logic [OFFSET_W-1:0] offset;
	} req_t;

	typedef struct packed {
		status_t             status;
		logic [OFFSET_W-1:0] alloc_offset;
	} rsp_t;

	typedef struct packed {
		kind_t               kind;
		logic [OFFSET_W-1:0] rel_off;
	} q_entry_t;

endpackage

`default_nettype wire

// ----- rtl/core/fbfl_front.sv -----
`default_nettype none

module fbfl_front import fbfl_pkg::*; #(
	parameter int NUM_SLOTS      = 1024,
	parameter int MAX_ITEM_BYTES = 4096,
	parameter int HEADER_BYTES   = 8
) (
	input  wire logic         req_valid,
	output logic              req_stall,
	input  wire req_t         req,
	input  wire logic [$clog2(NUM_SLOTS+1)+$clog2(MAX_ITEM_BYTES+HEADER_BYTES+1)-1:0] total,
	input  wire logic         sweeping,
	input  wire logic         q_full,
	output logic              q_push,
	output q_entry_t          q_entry
);

	localparam int IDX_W = $clog2(NUM_SLOTS + 1);
	localparam int SW    = $clog2(MAX_ITEM_BYTES + HEADER_BYTES + 1);
	localparam int TW    = IDX_W + SW;
	localparam int CW    = (TW > OFFSET_W) ? TW : OFFSET_W;

	logic [CW-1:0] off_ext;
	logic [CW-1:0] total_ext;
	logic          range_bad;

	assign off_ext   = CW'(req.offset);
	assign total_ext = CW'(total);
	assign range_bad = (req.offset < OFFSET_W'(HEADER_BYTES)) || (off_ext >= total_ext);

	assign req_stall = q_full || sweeping;
	assign q_push    = req_valid && !req_stall;

	always_comb begin
		q_entry.rel_off = req.offset - OFFSET_W'(HEADER_BYTES);
		if (!req.func) begin
			q_entry.kind = KIND_ALLOC;
		end else if (range_bad) begin
			q_entry.kind = KIND_RANGE;
		end else begin
			q_entry.kind = KIND_FREE;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/fbfl_fifo.sv -----
`default_nettype none

module fbfl_fifo import fbfl_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     push,
	input  wire q_entry_t push_data,
	output logic          full,
	input  wire logic     pop,
	output q_entry_t      pop_data,
	output logic          empty
);

	q_entry_t   slot_q [2];
	logic       wptr_q;
	logic       rptr_q;
	logic [1:0] cnt_q;

	assign full     = (cnt_q == 2'd2);
	assign empty    = (cnt_q == 2'd0);
	assign pop_data = slot_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (push) begin
				wptr_q <= !wptr_q;
			end
			if (pop) begin
				rptr_q <= !rptr_q;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wptr_q] <= push_data;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/fbfl_div.sv -----
`default_nettype none

module fbfl_div import fbfl_pkg::*; #(
	parameter int QW = 11,
	parameter int SW = 13
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	input  wire logic                abort,
	input  wire logic [OFFSET_W-1:0] dividend,
	input  wire logic [SW-1:0]       divisor,
	output logic                     done,
	output logic [QW-1:0]            quot,
	output logic                     rem_zero
);

	localparam int DW   = (OFFSET_W > SW + QW) ? OFFSET_W : SW + QW;
	localparam int CNTW = $clog2(QW);

	logic            busy_q;
	logic            done_q;
	logic [CNTW-1:0] cnt_q;
	logic [DW-1:0]   rem_q;
	logic [DW-1:0]   dsh_q;
	logic [QW-1:0]   quot_q;
	logic            fits;

	assign fits     = (rem_q >= dsh_q);
	assign done     = done_q;
	assign quot     = quot_q;
	assign rem_zero = (rem_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && !abort && !start && (cnt_q == '0);
			if (abort) begin
				busy_q <= 1'b0;
			end else if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNTW'(QW - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
				end else begin
					cnt_q <= cnt_q - CNTW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= DW'(dividend);
			dsh_q  <= DW'(divisor) << (QW - 1);
			quot_q <= '0;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= rem_q - dsh_q;
			end
			dsh_q  <= dsh_q >> 1;
			quot_q <= {quot_q[QW-2:0], fits};
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/fbfl_back.sv -----
`default_nettype none

module fbfl_back import fbfl_pkg::*; #(
	parameter int NUM_SLOTS      = 1024,
	parameter int MAX_ITEM_BYTES = 4096,
	parameter int HEADER_BYTES   = 8
) (
	input  wire logic                                           clk,
	input  wire logic                                           arst_n,
	input  wire logic                                           rebuild,
	input  wire logic [$clog2(NUM_SLOTS+1)-1:0]                 eff_n,
	input  wire logic [$clog2(MAX_ITEM_BYTES+HEADER_BYTES+1)-1:0] stride,
	input  wire logic                                           q_empty,
	input  wire q_entry_t                                       q_data,
	output logic                                                q_pop,
	output logic                                                sweeping,
	output logic                                                rsp_valid,
	input  wire logic                                           rsp_stall,
	output rsp_t                                                rsp
);

	localparam int IDX_W = $clog2(NUM_SLOTS + 1);
	localparam int AW    = $clog2(NUM_SLOTS);
	localparam int SW    = $clog2(MAX_ITEM_BYTES + HEADER_BYTES + 1);
	localparam int TW    = IDX_W + SW;
	localparam int CW    = (TW > OFFSET_W) ? TW : OFFSET_W;

	typedef enum logic [4:0] {
		B_SWEEP = 5'b00001,
		B_IDLE  = 5'b00010,
		B_FETCH = 5'b00100,
		B_DIV   = 5'b01000,
		B_HOLD  = 5'b10000
	} bstate_t;

	bstate_t          state_q;
	logic [AW-1:0]    sweep_cnt_q;
	logic [IDX_W-1:0] head_q;
	logic [IDX_W-1:0] count_q;
	logic [IDX_W-1:0] next_free_mem [NUM_SLOTS];
	logic [IDX_W-1:0] rdata_q;
	logic [TW-1:0]    prod_s1;
	logic             rsp_valid_q;
	rsp_t             rsp_q;
	rsp_t             hold_q;

	logic             div_start;
	logic             div_done;
	logic [IDX_W-1:0] div_quot;
	logic             div_rem_zero;

	logic             alloc_ok;
	logic             free_ok;
	logic [CW-1:0]    alloc_sum;
	logic             out_free;
	logic             rsp_load;
	logic             res_valid;
	rsp_t             res;
	logic             mem_we;
	logic [AW-1:0]    mem_waddr;
	logic [IDX_W-1:0] mem_wdata;

	assign q_pop     = (state_q == B_IDLE) && !q_empty;
	assign div_start = q_pop && (q_data.kind == KIND_FREE);
	assign sweeping  = (state_q == B_SWEEP);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign alloc_ok  = (count_q < eff_n) && (head_q < eff_n);
	assign free_ok   = div_rem_zero && (count_q != '0);
	assign alloc_sum = CW'(prod_s1) + CW'(HEADER_BYTES);
	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign rsp_load  = !rebuild && out_free && (res_valid || (state_q == B_HOLD));

	fbfl_div #(
		.QW (IDX_W),
		.SW (SW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.abort    (rebuild),
		.dividend (q_data.rel_off),
		.divisor  (stride),
		.done     (div_done),
		.quot     (div_quot),
		.rem_zero (div_rem_zero)
	);

	always_comb begin
		res_valid        = 1'b0;
		res.status       = STAT_ALLOC;
		res.alloc_offset = '0;
		case (state_q)
			B_IDLE: begin
				if (q_pop && (q_data.kind == KIND_RANGE)) begin
					res_valid  = 1'b1;
					res.status = STAT_RANGE;
				end
			end
			B_FETCH: begin
				res_valid = 1'b1;
				if (alloc_ok) begin
					res.alloc_offset = alloc_sum[OFFSET_W-1:0];
				end else begin
					res.status = STAT_EMPTY;
				end
			end
			B_DIV: begin
				if (div_done) begin
					res_valid  = 1'b1;
					res.status = free_ok ? STAT_FREED : STAT_ALIGN;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_SWEEP;
			sweep_cnt_q <= '0;
			head_q      <= '0;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			if (rebuild) begin
				state_q     <= B_SWEEP;
				sweep_cnt_q <= '0;
				head_q      <= '0;
				count_q     <= '0;
			end else begin
				case (state_q)
					B_SWEEP: begin
						sweep_cnt_q <= sweep_cnt_q + AW'(1);
						if (sweep_cnt_q == AW'(NUM_SLOTS - 1)) begin
							state_q <= B_IDLE;
						end
					end
					B_IDLE: begin
						if (q_pop) begin
							case (q_data.kind)
								KIND_ALLOC: state_q <= B_FETCH;
								KIND_FREE:  state_q <= B_DIV;
								default: begin
								end
							endcase
						end
					end
					B_FETCH: begin
						if (alloc_ok) begin
							head_q  <= rdata_q;
							count_q <= count_q + IDX_W'(1);
						end
					end
					B_DIV: begin
						if (div_done && free_ok) begin
							head_q  <= div_quot;
							count_q <= count_q - IDX_W'(1);
						end
					end
					B_HOLD: begin
						if (out_free) begin
							state_q <= B_IDLE;
						end
					end
					default: state_q <= B_IDLE;
				endcase
				if (res_valid) begin
					if (out_free) begin
						state_q <= B_IDLE;
					end else begin
						state_q <= B_HOLD;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= TW'(head_q) * TW'(stride);
		if (res_valid && out_free) begin
			rsp_q <= res;
		end else if ((state_q == B_HOLD) && out_free) begin
			rsp_q <= hold_q;
		end
		if (res_valid && !out_free) begin
			hold_q <= res;
		end
	end

	assign mem_we    = (state_q == B_SWEEP) || ((state_q == B_DIV) && div_done && free_ok);
	assign mem_waddr = (state_q == B_SWEEP) ? sweep_cnt_q : div_quot[AW-1:0];
	assign mem_wdata = (state_q == B_SWEEP) ? (IDX_W'(sweep_cnt_q) + IDX_W'(1)) : head_q;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			next_free_mem[mem_waddr] <= mem_wdata;
		end
		rdata_q <= next_free_mem[head_q[AW-1:0]];
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= eff_n)
		else $error("allocated count above slot count");

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_HOLD) |-> rsp_valid_q)
		else $error("result held while output register empty");

	a_div_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == B_DIV))
		else $error("divider finished outside free execution");

	a_zero_offset: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && (rsp_q.status != STAT_ALLOC)) |-> (rsp_q.alloc_offset == '0))
		else $error("nonzero offset on non-allocate result");

endmodule

`default_nettype wire

// ----- rtl/core/fixed_block_free_list_allocator.sv -----
`default_nettype none
// Channel | Dir | Handshake            | Beat
// req     | in  | req_valid/req_stall  | func, offset
// rsp     | out | rsp_valid/rsp_stall  | status, alloc_offset
// cfg     | in  | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
// Allocate: the back end registers the slot multiply and the next-index read.
// Free: one quotient bit per cycle in the stride divider; an out-of-range free
// is answered straight from the idle state.
// Reset and every write to either register start a pass that rewrites the
// next-index memory; req_stall stays high for its length.
// A two-beat queue lets req keep flowing while the back end works or rsp is stalled.

module fixed_block_free_list_allocator import fbfl_pkg::*; #(
	parameter int NUM_SLOTS      = 1024,
	parameter int MAX_ITEM_BYTES = 4096,
	parameter int HEADER_BYTES   = 8
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  req_valid,
	output logic                       req_stall,
	input  wire req_t                  req,
	output logic                       rsp_valid,
	input  wire logic                  rsp_stall,
	output rsp_t                       rsp,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int IDX_W = $clog2(NUM_SLOTS + 1);
	localparam int SW    = $clog2(MAX_ITEM_BYTES + HEADER_BYTES + 1);
	localparam int TW    = IDX_W + SW;

	logic [NUM_ITEMS_W-1:0] num_items_q;
	logic [ITEM_SIZE_W-1:0] item_size_q;
	logic [31:0]            n_wide;
	logic [31:0]            s_wide;
	logic [IDX_W-1:0]       eff_n;
	logic [SW-1:0]          stride;
	logic [TW-1:0]          total_q;
	logic                   cfg_wr;
	logic                   rebuild;
	logic                   sweeping;

	logic                   q_push;
	q_entry_t               q_push_data;
	logic                   q_full;
	logic                   q_pop;
	q_entry_t               q_pop_data;
	logic                   q_empty;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;
	assign rebuild   = cfg_wr && ((cfg_index == CFG_NUM_ITEMS) || (cfg_index == CFG_ITEM_SIZE));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_items_q <= NUM_ITEMS_RST;
			item_size_q <= ITEM_SIZE_RST;
		end else if (cfg_wr) begin
			case (cfg_index)
				CFG_NUM_ITEMS: num_items_q <= cfg_data[NUM_ITEMS_W-1:0];
				CFG_ITEM_SIZE: item_size_q <= cfg_data[ITEM_SIZE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// clamp registers into their legal ranges
	always_comb begin
		if (num_items_q == '0) begin
			n_wide = 32'd1;
		end else if (32'(num_items_q) > 32'(NUM_SLOTS)) begin
			n_wide = 32'(NUM_SLOTS);
		end else begin
			n_wide = 32'(num_items_q);
		end
		if (item_size_q == '0) begin
			s_wide = 32'd1 + 32'(HEADER_BYTES);
		end else if (32'(item_size_q) > 32'(MAX_ITEM_BYTES)) begin
			s_wide = 32'(MAX_ITEM_BYTES) + 32'(HEADER_BYTES);
		end else begin
			s_wide = 32'(item_size_q) + 32'(HEADER_BYTES);
		end
	end

	assign eff_n  = n_wide[IDX_W-1:0];
	assign stride = s_wide[SW-1:0];

	always_ff @(posedge clk) begin
		total_q <= TW'(eff_n) * TW'(stride);
	end

	fbfl_front #(
		.NUM_SLOTS      (NUM_SLOTS),
		.MAX_ITEM_BYTES (MAX_ITEM_BYTES),
		.HEADER_BYTES   (HEADER_BYTES)
	) u_front (
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.total     (total_q),
		.sweeping  (sweeping),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_entry   (q_push_data)
	);

	fbfl_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_push_data),
		.full      (q_full),
		.pop       (q_pop),
		.pop_data  (q_pop_data),
		.empty     (q_empty)
	);

	fbfl_back #(
		.NUM_SLOTS      (NUM_SLOTS),
		.MAX_ITEM_BYTES (MAX_ITEM_BYTES),
		.HEADER_BYTES   (HEADER_BYTES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.rebuild   (rebuild),
		.eff_n     (eff_n),
		.stride    (stride),
		.q_empty   (q_empty),
		.q_data    (q_pop_data),
		.q_pop     (q_pop),
		.sweeping  (sweeping),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule

`default_nettype wire
